@@ hdl/psg_pkg.sv @@
package psg_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int CPS_W             = 24;
  localparam logic [CPS_W-1:0] CPS_RESET = 24'd5319554;

  localparam int PERIOD_W = 10;
  localparam int COUNT_W  = 16;
  localparam int ATTEN_W  = 4;
  localparam int GAIN_W   = 15;
  localparam int ACC_W    = 18;
  localparam int SAMPLE_W = 16;
  localparam int NUM_TONES = 3;
  localparam int NUM_VOICES = 4;

  localparam logic [COUNT_W-1:0] NOISE_SEED = 16'h8000;

  // noise rate codes
  localparam logic [1:0] RATE_16  = 2'd0;
  localparam logic [1:0] RATE_32  = 2'd1;
  localparam logic [1:0] RATE_64  = 2'd2;
  localparam logic [1:0] RATE_TONE = 2'd3;

  // voice index of the noise channel
  localparam logic [1:0] VOICE_NOISE = 2'd3;

  // input op codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_MIX,
    ST_DONE
  } psg_state_t;

  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_data;
    logic       tick;
  } psg_core_ctrl_t;

  typedef struct packed {
    logic [NUM_VOICES-1:0]              polarity;
    logic [NUM_VOICES-1:0][ATTEN_W-1:0] atten;
  } psg_voice_status_t;

  typedef struct packed {
    logic       clear;
    logic       step;
    logic [1:0] voice;
  } psg_mix_ctrl_t;

  function automatic logic [GAIN_W-1:0] atten_gain(input logic [ATTEN_W-1:0] att);
    logic [GAIN_W-1:0] g;
    case (att)
      4'd0:    g = 15'd32767;
      4'd1:    g = 15'd26028;
      4'd2:    g = 15'd20675;
      4'd3:    g = 15'd16422;
      4'd4:    g = 15'd13045;
      4'd5:    g = 15'd10362;
      4'd6:    g = 15'd8231;
      4'd7:    g = 15'd6538;
      4'd8:    g = 15'd5193;
      4'd9:    g = 15'd4125;
      4'd10:   g = 15'd3276;
      4'd11:   g = 15'd2602;
      4'd12:   g = 15'd2067;
      4'd13:   g = 15'd1642;
      4'd14:   g = 15'd1304;
      default: g = 15'd0;
    endcase
    return g;
  endfunction

endpackage

@@ hdl/psg_if.sv @@
interface psg_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data;

  modport source (output valid, output op, output data, input ready);
  modport sink   (input valid, input op, input data, output ready);
endinterface

interface psg_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [psg_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/psg_voice_core.sv @@
module psg_voice_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psg_pkg::psg_core_ctrl_t     ctrl,
  output psg_pkg::psg_voice_status_t  status
);

  logic [psg_pkg::PERIOD_W-1:0] period_r [psg_pkg::NUM_TONES];
  logic [psg_pkg::PERIOD_W-1:0] period_nxt [psg_pkg::NUM_TONES];
  logic [psg_pkg::COUNT_W-1:0]  tcnt_r [psg_pkg::NUM_TONES];
  logic [psg_pkg::COUNT_W-1:0]  tcnt_nxt [psg_pkg::NUM_TONES];
  logic [psg_pkg::NUM_TONES-1:0] tpol_r, tpol_nxt;
  logic [psg_pkg::ATTEN_W-1:0]  att_r [psg_pkg::NUM_VOICES];
  logic [psg_pkg::ATTEN_W-1:0]  att_nxt [psg_pkg::NUM_VOICES];
  logic [psg_pkg::COUNT_W-1:0]  ncnt_r, ncnt_nxt;
  logic [psg_pkg::COUNT_W-1:0]  nsr_r, nsr_nxt;
  logic                         npol_r, npol_nxt;
  logic                         nwhite_r, nwhite_nxt;
  logic [1:0]                   nrate_r, nrate_nxt;
  logic [1:0]                   lvoice_r, lvoice_nxt;
  logic                         lvol_r, lvol_nxt;

  logic [psg_pkg::COUNT_W-1:0]  tdec;
  logic [psg_pkg::COUNT_W-1:0]  nreload;
  logic                         fb;
  logic [3:0]                   wv;
  logic [1:0]                   wvoice;

  always_comb begin
    for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
      period_nxt[i] = period_r[i];
      tcnt_nxt[i]   = tcnt_r[i];
    end
    for (int i = 0; i < psg_pkg::NUM_VOICES; i++) att_nxt[i] = att_r[i];
    tpol_nxt   = tpol_r;
    ncnt_nxt   = ncnt_r;
    nsr_nxt    = nsr_r;
    npol_nxt   = npol_r;
    nwhite_nxt = nwhite_r;
    nrate_nxt  = nrate_r;
    lvoice_nxt = lvoice_r;
    lvol_nxt   = lvol_r;
    tdec       = '0;
    fb         = 1'b0;
    wv         = ctrl.wr_data[3:0];
    wvoice     = ctrl.wr_data[6:5];

    case (nrate_r)
      psg_pkg::RATE_16: nreload = 16'd16;
      psg_pkg::RATE_32: nreload = 16'd32;
      psg_pkg::RATE_64: nreload = 16'd64;
      default: nreload = (period_r[2] != '0) ? {6'd0, period_r[2]} : 16'd1;
    endcase

    if (ctrl.wr_en) begin
      if (ctrl.wr_data[7]) begin
        // latch byte: select voice and register type
        lvoice_nxt = wvoice;
        lvol_nxt   = ctrl.wr_data[4];
        if (ctrl.wr_data[4]) begin
          for (int i = 0; i < psg_pkg::NUM_VOICES; i++)
            if (wvoice == 2'(i)) att_nxt[i] = wv;
        end else if (wvoice == psg_pkg::VOICE_NOISE) begin
          nwhite_nxt = wv[2];
          nrate_nxt  = wv[1:0];
          nsr_nxt    = psg_pkg::NOISE_SEED;
        end else begin
          for (int i = 0; i < psg_pkg::NUM_TONES; i++)
            if (wvoice == 2'(i)) period_nxt[i] = {period_r[i][9:4], wv};
        end
      end else if (!lvol_r && lvoice_r != psg_pkg::VOICE_NOISE) begin
        for (int i = 0; i < psg_pkg::NUM_TONES; i++)
          if (lvoice_r == 2'(i)) period_nxt[i] = {ctrl.wr_data[5:0], period_r[i][3:0]};
      end
    end else if (ctrl.tick) begin
      for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
        if (period_r[i] != '0) begin
          tdec = tcnt_r[i] - 16'd1;
          if (tdec == '0) begin
            tcnt_nxt[i] = {6'd0, period_r[i]};
            tpol_nxt[i] = ~tpol_r[i];
          end else begin
            tcnt_nxt[i] = tdec;
          end
        end
      end
      if (ncnt_r == '0) begin
        ncnt_nxt = nreload;
        fb       = nwhite_r ? (nsr_r[0] ^ nsr_r[3]) : nsr_r[0];
        nsr_nxt  = {fb, nsr_r[15:1]};
        npol_nxt = nsr_r[1];
      end else begin
        ncnt_nxt = ncnt_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
        period_r[i] <= '0;
        tcnt_r[i]   <= '0;
      end
      for (int i = 0; i < psg_pkg::NUM_VOICES; i++) att_r[i] <= '1;
      tpol_r   <= '1;
      ncnt_r   <= '0;
      nsr_r    <= psg_pkg::NOISE_SEED;
      npol_r   <= 1'b1;
      nwhite_r <= 1'b0;
      nrate_r  <= psg_pkg::RATE_16;
      lvoice_r <= '0;
      lvol_r   <= 1'b0;
    end else begin
      for (int i = 0; i < psg_pkg::NUM_TONES; i++) begin
        period_r[i] <= period_nxt[i];
        tcnt_r[i]   <= tcnt_nxt[i];
      end
      for (int i = 0; i < psg_pkg::NUM_VOICES; i++) att_r[i] <= att_nxt[i];
      tpol_r   <= tpol_nxt;
      ncnt_r   <= ncnt_nxt;
      nsr_r    <= nsr_nxt;
      npol_r   <= npol_nxt;
      nwhite_r <= nwhite_nxt;
      nrate_r  <= nrate_nxt;
      lvoice_r <= lvoice_nxt;
      lvol_r   <= lvol_nxt;
    end
  end

  always_comb begin
    status.polarity = {npol_r, tpol_r};
    for (int i = 0; i < psg_pkg::NUM_VOICES; i++) status.atten[i] = att_r[i];
  end

endmodule

@@ hdl/psg_mixer.sv @@
module psg_mixer (
  input  logic                               clk,
  input  logic                               rst_n,
  input  psg_pkg::psg_mix_ctrl_t             ctrl,
  input  psg_pkg::psg_voice_status_t         status,
  output logic signed [psg_pkg::SAMPLE_W-1:0] sample
);

  logic signed [psg_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic signed [psg_pkg::ACC_W-1:0] term;
  logic signed [psg_pkg::ACC_W-1:0] biased;
  logic signed [psg_pkg::ACC_W-1:0] quot;
  logic [psg_pkg::GAIN_W-1:0]       gain;

  always_comb begin
    gain = psg_pkg::atten_gain(status.atten[ctrl.voice]);
    term = status.polarity[ctrl.voice] ? $signed({3'd0, gain}) : -$signed({3'd0, gain});
    acc_nxt = acc_r;
    if (ctrl.clear)     acc_nxt = '0;
    else if (ctrl.step) acc_nxt = acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) acc_r <= '0;
    else        acc_r <= acc_nxt;
  end

  // divide by four, rounding toward zero, then clamp
  always_comb begin
    biased = acc_r[psg_pkg::ACC_W-1] ? acc_r + 18'sd3 : acc_r;
    quot   = biased >>> 2;
    if (quot > 18'sd32767)       sample = 16'sh7FFF;
    else if (quot < -18'sd32768) sample = 16'sh8000;
    else                         sample = quot[psg_pkg::SAMPLE_W-1:0];
  end

endmodule

@@ hdl/psg_tone_noise_generator.sv @@
// A write beat's register update lands at the accepting edge.
// A sample beat runs one chip tick per cycle, then four mix steps and an
// output step that waits for the output register; ticks = carry out of the
// clock step (81 or 82 at reset), set by the single shared tick datapath.
// Synchronous active-low reset restores all voice state, the step register
// and the fraction accumulator; there is no clearing pass.
module psg_tone_noise_generator #(
  parameter int FRACTION_BITS = psg_pkg::FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  psg_in_if.sink                    in_bus,
  psg_out_if.source                 out_bus,
  input  logic                      cfg_wr_en,
  input  logic [psg_pkg::CPS_W-1:0] cfg_wr_data
);

  localparam int SUM_W  = ((FRACTION_BITS > psg_pkg::CPS_W) ? FRACTION_BITS
                           : psg_pkg::CPS_W) + 1;
  localparam int TICK_W = SUM_W - FRACTION_BITS;

  psg_pkg::psg_state_t state_r, state_nxt;
  logic [psg_pkg::CPS_W-1:0]   cps_r;
  logic [FRACTION_BITS-1:0]    frac_r, frac_nxt;
  logic [TICK_W-1:0]           tick_cnt_r, tick_cnt_nxt;
  logic [1:0]                  mix_idx_r, mix_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [psg_pkg::SAMPLE_W-1:0] out_sample_r, out_sample_nxt;
  logic [SUM_W-1:0]            sum;
  logic                        in_fire;

  psg_pkg::psg_core_ctrl_t     core_ctrl;
  psg_pkg::psg_voice_status_t  status;
  psg_pkg::psg_mix_ctrl_t      mix_ctrl;
  logic signed [psg_pkg::SAMPLE_W-1:0] mix_sample;

  psg_voice_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (core_ctrl),
    .status (status)
  );

  psg_mixer u_mix (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mix_ctrl),
    .status (status),
    .sample (mix_sample)
  );

  assign in_bus.ready   = (state_r == psg_pkg::ST_IDLE);
  assign in_fire        = in_bus.valid && in_bus.ready;
  assign out_bus.valid  = out_valid_r;
  assign out_bus.sample = out_sample_r;
  assign sum = SUM_W'(frac_r) + SUM_W'(cps_r);

  always_comb begin
    state_nxt      = state_r;
    frac_nxt       = frac_r;
    tick_cnt_nxt   = tick_cnt_r;
    mix_idx_nxt    = mix_idx_r;
    out_sample_nxt = out_sample_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    core_ctrl.wr_en   = 1'b0;
    core_ctrl.wr_data = in_bus.data;
    core_ctrl.tick    = 1'b0;
    mix_ctrl.clear = 1'b0;
    mix_ctrl.step  = 1'b0;
    mix_ctrl.voice = mix_idx_r;

    case (state_r)
      psg_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_bus.op == psg_pkg::OP_WRITE) begin
            core_ctrl.wr_en = 1'b1;
          end else begin
            frac_nxt       = sum[FRACTION_BITS-1:0];
            tick_cnt_nxt   = sum[SUM_W-1:FRACTION_BITS];
            mix_idx_nxt    = '0;
            mix_ctrl.clear = 1'b1;
            state_nxt = (sum[SUM_W-1:FRACTION_BITS] == '0) ? psg_pkg::ST_MIX
                                                           : psg_pkg::ST_TICK;
          end
        end
      end
      psg_pkg::ST_TICK: begin
        core_ctrl.tick = 1'b1;
        tick_cnt_nxt   = tick_cnt_r - TICK_W'(1);
        if (tick_cnt_r == TICK_W'(1)) state_nxt = psg_pkg::ST_MIX;
      end
      psg_pkg::ST_MIX: begin
        mix_ctrl.step = 1'b1;
        mix_idx_nxt   = mix_idx_r + 2'd1;
        if (mix_idx_r == psg_pkg::VOICE_NOISE) state_nxt = psg_pkg::ST_DONE;
      end
      psg_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_bus.ready) begin
          out_sample_nxt = mix_sample;
          out_valid_nxt  = 1'b1;
          state_nxt      = psg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psg_pkg::ST_IDLE;
      cps_r       <= psg_pkg::CPS_RESET;
      frac_r      <= '0;
      tick_cnt_r  <= '0;
      mix_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_wr_en) cps_r <= cfg_wr_data;
      frac_r      <= frac_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      mix_idx_r   <= mix_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
  end

  a_tick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psg_pkg::ST_TICK) |-> (tick_cnt_r != '0))
    else $error("tick sequencer running with zero count");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_bus.op == psg_pkg::OP_WRITE) |=> (state_r == psg_pkg::ST_IDLE))
    else $error("write beat left the idle state");

  a_mix_four: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psg_pkg::ST_MIX && mix_idx_r == psg_pkg::VOICE_NOISE)
      |=> (state_r == psg_pkg::ST_DONE))
    else $error("mix did not finish after four voices");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psg_pkg::ST_DONE && state_nxt == psg_pkg::ST_IDLE) |=> out_valid_r)
    else $error("sample finished without loading the output register");

endmodule
